[rtl/utf8_stream_decoder_top_defines.svh]
// assertion helpers used by the top-level file to check the decoder
`ifndef UTF8_STREAM_DECODER_TOP_DEFINES_SVH
`define UTF8_STREAM_DECODER_TOP_DEFINES_SVH

// same-cycle implication, masked while reset is asserted
`define UTF8SD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("utf8sd check failed");

// next-cycle implication, masked while reset is asserted
`define UTF8SD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("utf8sd check failed");

`endif

[rtl/utf8sd_pkg.sv]
package utf8sd_pkg;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_INVALID = 2'd1,
		STATUS_TRUNC   = 2'd2
	} status_t;

	// classified byte; lead_len 0 marks a byte that cannot open a sequence
	typedef struct packed {
		logic [2:0] lead_len;
		logic [6:0] lead_bits;
		logic [5:0] cont_bits;
		logic       last;
	} entry_t;

	// one queue port: valid flag plus the classified byte
	typedef struct packed {
		logic   valid;
		entry_t entry;
	} q_req_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

[rtl/utf8sd_channels.sv]
interface utf8sd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_text;

	modport source (output valid, in_byte, end_of_text, input ready);
	modport sink   (input valid, in_byte, end_of_text, output ready);
endinterface

interface utf8sd_char_if;
	logic        valid;
	logic        ready;
	logic [30:0] code_point;
	logic [2:0]  seq_length;
	logic [1:0]  status;

	modport source (output valid, code_point, seq_length, status, input ready);
	modport sink   (input valid, code_point, seq_length, status, output ready);
endinterface

[rtl/utf8sd_front.sv]
module utf8sd_front (
	utf8sd_byte_if.sink        byte_ch,
	input  utf8sd_pkg::q_stat_t q_stat,
	output utf8sd_pkg::q_req_t  q_wr
);

	localparam logic [7:0] MASK_1 = 8'h80;
	localparam logic [7:0] MASK_2 = 8'hE0;
	localparam logic [7:0] MASK_3 = 8'hF0;
	localparam logic [7:0] MASK_4 = 8'hF8;
	localparam logic [7:0] MASK_5 = 8'hFC;
	localparam logic [7:0] MASK_6 = 8'hFE;

	logic [7:0] b;
	utf8sd_pkg::entry_t ent;

	assign b = byte_ch.in_byte;

	// lead class from the prefix; top bits masked by class
	always_comb begin
		ent.cont_bits = b[5:0];
		ent.last      = byte_ch.end_of_text;
		ent.lead_len  = 3'd0;
		ent.lead_bits = 7'd0;
		if ((b & MASK_1) == 8'h00) begin
			ent.lead_len  = 3'd1;
			ent.lead_bits = b[6:0];
		end else if ((b & MASK_2) == 8'hC0) begin
			ent.lead_len  = 3'd2;
			ent.lead_bits = {2'b00, b[4:0]};
		end else if ((b & MASK_3) == 8'hE0) begin
			ent.lead_len  = 3'd3;
			ent.lead_bits = {3'b000, b[3:0]};
		end else if ((b & MASK_4) == 8'hF0) begin
			ent.lead_len  = 3'd4;
			ent.lead_bits = {4'b0000, b[2:0]};
		end else if ((b & MASK_5) == 8'hF8) begin
			ent.lead_len  = 3'd5;
			ent.lead_bits = {5'b00000, b[1:0]};
		end else if ((b & MASK_6) == 8'hFC) begin
			ent.lead_len  = 3'd6;
			ent.lead_bits = {6'b000000, b[0]};
		end
	end

	assign byte_ch.ready = !q_stat.full;
	assign q_wr.valid    = byte_ch.valid && !q_stat.full;
	assign q_wr.entry    = ent;

endmodule

[rtl/utf8sd_queue.sv]
module utf8sd_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  utf8sd_pkg::q_req_t  q_wr,
	input  logic                pop,
	output utf8sd_pkg::q_req_t  q_head,
	output utf8sd_pkg::q_stat_t q_stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	utf8sd_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             do_pop;

	assign push   = q_wr.valid;
	assign do_pop = pop && (cnt_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= q_wr.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign q_head.valid = (cnt_q != '0);
	assign q_head.entry = mem_q[rd_ptr_q];
	assign q_stat.full  = (cnt_q == CNT_W'(DEPTH));
	assign q_stat.empty = (cnt_q == '0);

endmodule

[rtl/utf8sd_back.sv]
module utf8sd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  utf8sd_pkg::q_req_t q_head,
	output logic               pop,
	utf8sd_char_if.source      char_ch
);

	logic [30:0] acc_q;
	logic [2:0]  pend_q;
	logic [2:0]  seq_len_q;
	logic        out_valid_q;
	logic [30:0] cp_q;
	logic [2:0]  len_q;
	logic [1:0]  st_q;

	logic [30:0] acc_d;
	logic [2:0]  pend_d;
	logic [2:0]  seq_len_d;
	logic        emit;
	logic [30:0] emit_cp;
	logic [2:0]  emit_len;
	utf8sd_pkg::status_t emit_st;
	logic [30:0] acc_shift;
	logic [2:0]  pend_dec;
	utf8sd_pkg::entry_t e;

	assign e         = q_head.entry;
	assign pop       = q_head.valid && (!out_valid_q || char_ch.ready);
	assign acc_shift = {acc_q[24:0], e.cont_bits};
	assign pend_dec  = pend_q - 3'd1;

	always_comb begin
		acc_d     = acc_q;
		pend_d    = pend_q;
		seq_len_d = seq_len_q;
		emit      = 1'b0;
		emit_cp   = '0;
		emit_len  = 3'd1;
		emit_st   = utf8sd_pkg::STATUS_OK;
		if (pend_q == 3'd0) begin
			if (e.lead_len == 3'd1) begin
				emit    = 1'b1;
				emit_cp = {24'd0, e.lead_bits};
			end else if (e.lead_len == 3'd0) begin
				emit    = 1'b1;
				emit_st = utf8sd_pkg::STATUS_INVALID;
			end else if (e.last) begin
				emit    = 1'b1;
				emit_st = utf8sd_pkg::STATUS_TRUNC;
			end else begin
				acc_d     = {24'd0, e.lead_bits};
				pend_d    = e.lead_len - 3'd1;
				seq_len_d = e.lead_len;
			end
		end else begin
			if (pend_dec == 3'd0) begin
				emit      = 1'b1;
				emit_cp   = acc_shift;
				emit_len  = seq_len_q;
				acc_d     = '0;
				pend_d    = '0;
				seq_len_d = '0;
			end else if (e.last) begin
				emit      = 1'b1;
				emit_len  = seq_len_q - pend_dec;
				emit_st   = utf8sd_pkg::STATUS_TRUNC;
				acc_d     = '0;
				pend_d    = '0;
				seq_len_d = '0;
			end else begin
				acc_d  = acc_shift;
				pend_d = pend_dec;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			pend_q      <= '0;
			seq_len_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				acc_q     <= acc_d;
				pend_q    <= pend_d;
				seq_len_q <= seq_len_d;
			end
			if (pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (char_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload only loads with a new result
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			cp_q  <= emit_cp;
			len_q <= emit_len;
			st_q  <= emit_st;
		end
	end

	assign char_ch.valid      = out_valid_q;
	assign char_ch.code_point = cp_q;
	assign char_ch.seq_length = len_q;
	assign char_ch.status     = st_q;

endmodule

[rtl/utf8_stream_decoder_top.sv]
// six-byte legacy utf-8 decoder, one byte in per transfer
// byte_ch: raw bytes; end_of_text marks the last byte of a text
// char_ch: one transfer per finished character with code_point, seq_length
//   and status (ok, invalid lead byte, truncated at end of text)
// bytes that only continue an open sequence give no char_ch transfer
// path: a taken byte is written into the queue, popped by the back end, and any
//   result is registered in the output register that drives char_ch
// throughput: one byte per cycle while char_ch does not stall, set by the single
//   shift-and-or step of the back-end accumulator per queued byte
// the front classifies each byte by its prefix and writes it into a queue of
//   QUEUE_DEPTH entries; the back end pops it and updates the open sequence
// reset clears the queue pointers, the open sequence and the output valid;
//   the first byte after reset is taken as a lead byte
// when char_ch stalls the output register holds its result, the back end
//   stops popping, the queue fills and byte_ch ready drops once it is full
`include "utf8_stream_decoder_top_defines.svh"

module utf8_stream_decoder_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input logic           clk,
	input logic           arst_n,
	utf8sd_byte_if.sink   byte_ch,
	utf8sd_char_if.source char_ch
);

	// queue write port, head and fill status
	utf8sd_pkg::q_req_t  q_wr;
	utf8sd_pkg::q_req_t  q_head;
	utf8sd_pkg::q_stat_t q_stat;
	logic                pop;

	// front: classify the lead prefix, push when the queue has room
	utf8sd_front u_front (
		.byte_ch (byte_ch),
		.q_stat  (q_stat),
		.q_wr    (q_wr)
	);

	// short queue that decouples byte intake from result delivery
	utf8sd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.pop    (pop),
		.q_head (q_head),
		.q_stat (q_stat)
	);

	// back: sequence accumulator and registered result
	utf8sd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_head  (q_head),
		.pop     (pop),
		.char_ch (char_ch)
	);

	// the back end only pops a queued byte
	`UTF8SD_ASSERT_NOW(a_pop_has_head, clk, arst_n, pop, q_head.valid)
	// a pop never overwrites a result that is still waiting
	`UTF8SD_ASSERT_NOW(a_pop_no_overrun, clk, arst_n, pop, !char_ch.valid || char_ch.ready)
	// a full queue always has a head, and a full queue stops byte intake
	`UTF8SD_ASSERT_NOW(a_full_blocks, clk, arst_n, q_stat.full, q_head.valid && !byte_ch.ready)
	// an accepted byte leaves the queue non-empty at the next edge
	`UTF8SD_ASSERT_NEXT(a_push_fills, clk, arst_n, byte_ch.valid && byte_ch.ready && !pop,
		!q_stat.empty)

endmodule
